FILE: rtl/lmts_pkg.sv
// Package for the LCD mode timing sequencer: mode codes, request kinds,
// register indexes and the line/tick timing constants.
// No dependencies.
`default_nettype none

package lmts_pkg;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   typedef enum logic {
      REQ_TICK       = 1'b0,
      REQ_LCDC_WRITE = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_LINE_COMPARE = 1'b0,
      CSR_IRQ_ENABLES  = 1'b1
   } csr_index_type;

   // stat_irq_enables bit positions
   localparam int unsigned IRQ_EN_HBLANK = 0;
   localparam int unsigned IRQ_EN_VBLANK = 1;
   localparam int unsigned IRQ_EN_OAM    = 2;
   localparam int unsigned IRQ_EN_COINC  = 3;

   localparam logic [9:0] LEN_OAM        = 10'd80;
   localparam logic [9:0] LEN_XFER       = 10'd172;
   localparam logic [9:0] LEN_HBLANK     = 10'd204;
   localparam logic [9:0] LEN_LINE       = 10'd456;
   localparam logic [9:0] TICK_LINE153   = 10'd4;
   localparam logic [9:0] TICKS_RESTART  = 10'd1022;

   localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
   localparam logic [7:0] LINES_TOTAL       = 8'd154;
   localparam logic [7:0] LAST_LINE         = 8'd153;
   localparam logic [7:0] ENABLE_HOLD       = 8'd244;

endpackage

`default_nettype wire

FILE: rtl/lmts_ifs.sv
// Handshake channels of the LCD mode timing sequencer: request and response.
// Depends on lmts_pkg.
`default_nettype none

interface lmts_req_if
   import lmts_pkg::*;
();
   logic         valid;
   logic         ready;
   req_kind_type req_type;
   logic         lcd_enable;

   modport source (output valid, req_type, lcd_enable, input ready);
   modport sink   (input valid, req_type, lcd_enable, output ready);
endinterface

interface lmts_rsp_if
   import lmts_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] line;
   mode_type   shown_mode;
   logic       coincidence;
   logic       lcd_irq;
   logic       vblank_irq;
   logic       render_line;

   modport source (output valid, line, shown_mode, coincidence, lcd_irq, vblank_irq,
                   render_line, input ready);
   modport sink   (input valid, line, shown_mode, coincidence, lcd_irq, vblank_irq,
                   render_line, output ready);
endinterface

`default_nettype wire

FILE: rtl/lcd_mode_timing_sequencer_core.sv
// LCD mode timing sequencer top level: line/mode counters, enable delay,
// status flags and interrupt pulses. Depends on lmts_pkg and lmts_ifs.
//
//   channel   dir  handshake       word
//   req_chan  in   valid/ready     req_type, lcd_enable
//   rsp_chan  out  valid/ready     line, shown_mode, coincidence, lcd_irq,
//                                  vblank_irq, render_line
//   csr_*     in   csr_wr_en       csr_index, csr_wdata
//
// One word per cycle unless the response side stalls; each request word yields its response
// word in the cycle after acceptance, from the single response register.
// req_chan.ready drops only while the response register is full and stalled.
// Reset (synchronous) clears all counters: mode OAM, line 0, LCD off.
`default_nettype none

module lcd_mode_timing_sequencer_core
   import lmts_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   lmts_req_if.sink   req_chan,
   lmts_rsp_if.source rsp_chan,
   input  wire        csr_wr_en,
   input  wire        csr_index,
   input  wire [7:0]  csr_wdata
);

   logic [7:0] line_compare_ff;
   logic [3:0] irq_en_ff;

   logic [9:0] mode_ticks_ff,  mode_ticks_in;
   logic [7:0] line_count_ff,  line_count_in;
   mode_type   cur_mode_ff,    cur_mode_in;
   mode_type   shown_mode_ff,  shown_mode_in;
   logic       coinc_ff,       coinc_in;
   logic       lcd_on_ff,      lcd_on_in;
   logic       was_off_ff,     was_off_in;
   logic [7:0] enable_wait_ff, enable_wait_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_line_ff;
   mode_type   rsp_mode_ff;
   logic       rsp_coinc_ff, rsp_lcd_irq_ff, rsp_vblank_irq_ff, rsp_render_ff;

   logic       accept;
   logic       go;
   logic [9:0] ticks_inc;
   logic [7:0] line_inc;
   logic [7:0] wait_dec;
   logic       lcd_irq, vblank_irq, render;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign ticks_inc = mode_ticks_ff + 10'd1;
   assign line_inc  = line_count_ff + 8'd1;
   assign wait_dec  = enable_wait_ff - 8'd1;

   // a tick advances the counters while the LCD is on and the enable delay has run out
   assign go = (req_chan.req_type == REQ_TICK) && lcd_on_ff &&
               (!was_off_ff || (wait_dec == 8'd0));

   // next state
   always_comb begin
      mode_ticks_in  = mode_ticks_ff;
      line_count_in  = line_count_ff;
      cur_mode_in    = cur_mode_ff;
      shown_mode_in  = shown_mode_ff;
      coinc_in       = coinc_ff;
      lcd_on_in      = lcd_on_ff;
      was_off_in     = was_off_ff;
      enable_wait_in = enable_wait_ff;
      if (req_chan.req_type == REQ_LCDC_WRITE) begin
         lcd_on_in      = req_chan.lcd_enable;
         enable_wait_in = ENABLE_HOLD;
         if (!req_chan.lcd_enable) begin
            mode_ticks_in = TICKS_RESTART;
            was_off_in    = 1'b1;
            line_count_in = 8'd0;
            shown_mode_in = MODE_HBLANK;
            coinc_in      = (line_compare_ff == 8'd0);
         end
      end else if (lcd_on_ff) begin
         if (was_off_ff) begin
            enable_wait_in = wait_dec;
            if (wait_dec == 8'd0) begin
               was_off_in = 1'b0;
            end
         end
         if (go) begin
            mode_ticks_in = ticks_inc;
            case (cur_mode_ff)
               MODE_OAM: begin
                  if (ticks_inc == LEN_OAM) begin
                     mode_ticks_in = 10'd0;
                     cur_mode_in   = MODE_XFER;
                  end
               end
               MODE_XFER: begin
                  if (ticks_inc == LEN_XFER) begin
                     mode_ticks_in = 10'd0;
                     cur_mode_in   = MODE_HBLANK;
                  end
               end
               MODE_HBLANK: begin
                  if (ticks_inc == LEN_HBLANK) begin
                     mode_ticks_in = 10'd0;
                     line_count_in = line_inc;
                     cur_mode_in   = (line_inc == FIRST_VBLANK_LINE) ? MODE_VBLANK : MODE_OAM;
                  end
               end
               default: begin
                  if (ticks_inc == LEN_LINE) begin
                     mode_ticks_in = 10'd0;
                     if (line_inc == LINES_TOTAL) begin
                        line_count_in = 8'd0;
                        cur_mode_in   = MODE_OAM;
                     end else begin
                        line_count_in = line_inc;
                     end
                  end
               end
            endcase
            shown_mode_in = cur_mode_in;
            coinc_in      = (line_count_in == line_compare_ff);
         end
      end
   end

   // pulses
   always_comb begin
      lcd_irq    = 1'b0;
      vblank_irq = 1'b0;
      render     = 1'b0;
      if (go) begin
         case (cur_mode_ff)
            MODE_XFER: begin
               if (ticks_inc == LEN_XFER) begin
                  render  = 1'b1;
                  lcd_irq = irq_en_ff[IRQ_EN_HBLANK] ||
                            (irq_en_ff[IRQ_EN_COINC] && (line_count_ff == line_compare_ff));
               end
            end
            MODE_HBLANK: begin
               if ((ticks_inc == LEN_HBLANK) && (line_inc == FIRST_VBLANK_LINE)) begin
                  vblank_irq = 1'b1;
                  lcd_irq    = irq_en_ff[IRQ_EN_VBLANK];
               end
            end
            MODE_VBLANK: begin
               lcd_irq = irq_en_ff[IRQ_EN_OAM] &&
                         (((ticks_inc == TICK_LINE153) && (line_count_ff == LAST_LINE)) ||
                          ((ticks_inc == LEN_LINE) && (line_inc == LINES_TOTAL)));
            end
            default: begin
               lcd_irq = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_compare_ff <= 8'd0;
         irq_en_ff       <= 4'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_COMPARE: line_compare_ff <= csr_wdata;
            CSR_IRQ_ENABLES:  irq_en_ff       <= csr_wdata[3:0];
            default:          irq_en_ff       <= irq_en_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ticks_ff  <= 10'd0;
         line_count_ff  <= 8'd0;
         cur_mode_ff    <= MODE_OAM;
         shown_mode_ff  <= MODE_HBLANK;
         coinc_ff       <= 1'b0;
         lcd_on_ff      <= 1'b0;
         was_off_ff     <= 1'b0;
         enable_wait_ff <= 8'd0;
      end else if (accept) begin
         mode_ticks_ff  <= mode_ticks_in;
         line_count_ff  <= line_count_in;
         cur_mode_ff    <= cur_mode_in;
         shown_mode_ff  <= shown_mode_in;
         coinc_ff       <= coinc_in;
         lcd_on_ff      <= lcd_on_in;
         was_off_ff     <= was_off_in;
         enable_wait_ff <= enable_wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload: load on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_line_ff       <= line_count_in;
         rsp_mode_ff       <= shown_mode_in;
         rsp_coinc_ff      <= coinc_in;
         rsp_lcd_irq_ff    <= lcd_irq;
         rsp_vblank_irq_ff <= vblank_irq;
         rsp_render_ff     <= render;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.line        = rsp_line_ff;
   assign rsp_chan.shown_mode  = rsp_mode_ff;
   assign rsp_chan.coincidence = rsp_coinc_ff;
   assign rsp_chan.lcd_irq     = rsp_lcd_irq_ff;
   assign rsp_chan.vblank_irq  = rsp_vblank_irq_ff;
   assign rsp_chan.render_line = rsp_render_ff;

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      line_count_ff <= LAST_LINE)
      else $error("line counter out of range");

   a_vblank_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_vblank_irq_ff) |-> (rsp_mode_ff == MODE_VBLANK))
      else $error("vblank pulse outside VBlank");

   a_render_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_render_ff) |-> (rsp_mode_ff == MODE_HBLANK))
      else $error("render strobe outside HBlank");

   a_off_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.req_type == REQ_TICK) && !lcd_on_ff)
      |=> ($stable(line_count_ff) && $stable(mode_ticks_ff)))
      else $error("counters moved while LCD off");

endmodule

`default_nettype wire

FILE: tb/sv/lcd_mode_timing_sequencer_core_tb.sv
// Testbench for lcd_mode_timing_sequencer_core: drives ticks and LCD control writes,
// checks every response word against a cycle-free line/mode model or a pinned plan word.
// Depends on lmts_pkg, lmts_ifs and the core RTL.
`timescale 1ns / 100ps

module lcd_mode_timing_sequencer_core_tb;
   import lmts_pkg::*;

   typedef struct packed {
      logic [7:0] line;
      mode_type   shown_mode;
      logic       coincidence;
      logic       lcd_irq;
      logic       vblank_irq;
      logic       render_line;
   } status_word_type;

   typedef struct packed {
      req_kind_type    kind;
      logic            enable;
      logic            pinned;
      status_word_type word;
   } plan_row_type;

   localparam int PLAN_LEN      = 20;
   localparam int PHASES        = 6;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;

   localparam status_word_type HELD_OFF   = '{8'd0, MODE_HBLANK, 1'b0, 1'b0, 1'b0, 1'b0};
   localparam status_word_type HELD_COINC = '{8'd0, MODE_HBLANK, 1'b1, 1'b0, 1'b0, 1'b0};
   localparam status_word_type FIRST_OAM  = '{8'd0, MODE_OAM, 1'b1, 1'b0, 1'b0, 1'b0};

   // opening sequence: ticks while off, enable, first OAM dot, disable, enable delay
   localparam plan_row_type DIRECTED_PLAN [PLAN_LEN] = '{
      '{REQ_TICK,       1'b0, 1'b1, HELD_OFF},
      '{REQ_TICK,       1'b1, 1'b1, HELD_OFF},
      '{REQ_LCDC_WRITE, 1'b1, 1'b1, HELD_OFF},
      '{REQ_TICK,       1'b0, 1'b1, FIRST_OAM},
      '{REQ_TICK,       1'b1, 1'b0, HELD_OFF},
      '{REQ_LCDC_WRITE, 1'b1, 1'b0, HELD_OFF},
      '{REQ_TICK,       1'b0, 1'b0, HELD_OFF},
      '{REQ_LCDC_WRITE, 1'b0, 1'b1, HELD_COINC},
      '{REQ_LCDC_WRITE, 1'b0, 1'b1, HELD_COINC},
      '{REQ_TICK,       1'b1, 1'b1, HELD_COINC},
      '{REQ_LCDC_WRITE, 1'b1, 1'b1, HELD_COINC},
      '{REQ_TICK,       1'b0, 1'b1, HELD_COINC},
      '{REQ_TICK,       1'b1, 1'b0, HELD_OFF},
      '{REQ_LCDC_WRITE, 1'b1, 1'b0, HELD_OFF},
      '{REQ_TICK,       1'b0, 1'b0, HELD_OFF},
      '{REQ_TICK,       1'b1, 1'b0, HELD_OFF},
      '{REQ_LCDC_WRITE, 1'b0, 1'b0, HELD_OFF},
      '{REQ_LCDC_WRITE, 1'b1, 1'b0, HELD_OFF},
      '{REQ_TICK,       1'b0, 1'b0, HELD_OFF},
      '{REQ_TICK,       1'b0, 1'b0, HELD_OFF}
   };

   // the first three phases run through the enable delay and up to the end of transfer
   localparam int PHASE_LEN    [PHASES] = '{246, 130, 125, 20, 10, 10};
   localparam int PHASE_WRITES [PHASES] = '{0, 0, 0, 2000, 1000, 2000};

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_idx;
   logic [7:0]    csr_wdata;

   lmts_req_if req_bus ();
   lmts_rsp_if rsp_bus ();

   lcd_mode_timing_sequencer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // sequencer model state
   logic [7:0] cmp_line;
   logic [3:0] irq_en;
   logic [9:0] tick_cnt;
   logic [7:0] line_m;
   mode_type   mode_m;
   mode_type   shown_m;
   logic       coinc_m;
   logic       lcd_on_m;
   logic       off_seen;
   logic [7:0] hold_cnt;

   status_word_type status_q [$];
   plan_row_type    pin_q [$];

   int fail_count   = 0;
   int n_requests   = 0;
   int n_results    = 0;
   int n_lcd_irq    = 0;
   int n_vblank_irq = 0;
   int n_render     = 0;
   int n_settings   = 0;
   bit gaps_on      = 1'b1;
   bit hold_rsp     = 1'b0;

   task automatic clear_lcd_timing();
      cmp_line = 8'd0;
      irq_en   = 4'd0;
      tick_cnt = 10'd0;
      line_m   = 8'd0;
      mode_m   = MODE_OAM;
      shown_m  = MODE_HBLANK;
      coinc_m  = 1'b0;
      lcd_on_m = 1'b0;
      off_seen = 1'b0;
      hold_cnt = 8'd0;
   endtask

   task automatic advance_lcd_timing(input req_kind_type kind, input logic en_bit,
                                     output status_word_type w);
      logic go;
      w.lcd_irq     = 1'b0;
      w.vblank_irq  = 1'b0;
      w.render_line = 1'b0;
      if (kind == REQ_LCDC_WRITE) begin
         lcd_on_m = en_bit;
         hold_cnt = ENABLE_HOLD;
         if (!en_bit) begin
            // mode is kept; counter restarts two dots early
            tick_cnt = TICKS_RESTART;
            off_seen = 1'b1;
            line_m   = 8'd0;
            shown_m  = MODE_HBLANK;
            coinc_m  = (line_m == cmp_line);
         end
      end else if (lcd_on_m) begin
         go = 1'b1;
         if (off_seen) begin
            hold_cnt = hold_cnt - 8'd1;
            if (hold_cnt == 8'd0) begin
               off_seen = 1'b0;
            end else begin
               go = 1'b0;
            end
         end
         if (go) begin
            tick_cnt = tick_cnt + 10'd1;
            case (mode_m)
               MODE_OAM: begin
                  if (tick_cnt == LEN_OAM) begin
                     tick_cnt = 10'd0;
                     mode_m   = MODE_XFER;
                  end
               end
               MODE_XFER: begin
                  if (tick_cnt == LEN_XFER) begin
                     tick_cnt      = 10'd0;
                     mode_m        = MODE_HBLANK;
                     w.render_line = 1'b1;
                     if (line_m == cmp_line && irq_en[IRQ_EN_COINC]) w.lcd_irq = 1'b1;
                     if (irq_en[IRQ_EN_HBLANK]) w.lcd_irq = 1'b1;
                  end
               end
               MODE_HBLANK: begin
                  if (tick_cnt == LEN_HBLANK) begin
                     tick_cnt = 10'd0;
                     line_m   = line_m + 8'd1;
                     if (line_m == FIRST_VBLANK_LINE) begin
                        mode_m       = MODE_VBLANK;
                        w.vblank_irq = 1'b1;
                        if (irq_en[IRQ_EN_VBLANK]) w.lcd_irq = 1'b1;
                     end else begin
                        mode_m = MODE_OAM;
                     end
                  end
               end
               default: begin
                  if (tick_cnt == TICK_LINE153 && line_m == LAST_LINE && irq_en[IRQ_EN_OAM])
                     w.lcd_irq = 1'b1;
                  if (tick_cnt == LEN_LINE) begin
                     tick_cnt = 10'd0;
                     line_m   = line_m + 8'd1;
                     if (line_m == LINES_TOTAL) begin
                        mode_m = MODE_OAM;
                        line_m = 8'd0;
                        if (irq_en[IRQ_EN_OAM]) w.lcd_irq = 1'b1;
                     end
                  end
               end
            endcase
            shown_m = mode_m;
            coinc_m = (line_m == cmp_line);
         end
      end
      w.line        = line_m;
      w.shown_mode  = shown_m;
      w.coincidence = coinc_m;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #24_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_bus.ready <= !(gaps_on && $urandom_range(0, 99) < 13);
      end
   end

   always @(posedge clock) begin : monitor_blk
      status_word_type got;
      status_word_type want;
      plan_row_type    pin;
      if (reset) begin
         clear_lcd_timing();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.line        = rsp_bus.line;
            got.shown_mode  = rsp_bus.shown_mode;
            got.coincidence = rsp_bus.coincidence;
            got.lcd_irq     = rsp_bus.lcd_irq;
            got.vblank_irq  = rsp_bus.vblank_irq;
            got.render_line = rsp_bus.render_line;
            n_results++;
            n_lcd_irq    += got.lcd_irq;
            n_vblank_irq += got.vblank_irq;
            n_render     += got.render_line;
            if (status_q.size() == 0) begin
               $error("response word with nothing expected");
               fail_count++;
            end else begin
               want = status_q.pop_front();
               check_field("line", want.line, got.line);
               check_field("shown_mode", want.shown_mode, got.shown_mode);
               check_field("coincidence", want.coincidence, got.coincidence);
               check_field("lcd_irq", want.lcd_irq, got.lcd_irq);
               check_field("vblank_irq", want.vblank_irq, got.vblank_irq);
               check_field("render_line", want.render_line, got.render_line);
            end
         end
         if (csr_wr_en) begin
            case (csr_idx)
               CSR_LINE_COMPARE: cmp_line = csr_wdata;
               CSR_IRQ_ENABLES:  irq_en   = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            pin = pin_q.pop_front();
            advance_lcd_timing(req_bus.req_type, req_bus.lcd_enable, want);
            if (pin.pinned) want = pin.word;
            status_q = {status_q, want};
            n_requests++;
         end
      end
   end

   // call at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input req_kind_type kind, input logic en_bit,
                            input logic pinned, input status_word_type word);
      plan_row_type row;
      row   = '{kind, en_bit, pinned, word};
      pin_q = {pin_q, row};
      while (gaps_on && $urandom_range(0, 99) < 13) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.lcd_enable <= en_bit;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (status_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_settings(input logic [7:0] lc, input logic [7:0] en);
      csr_wr_en <= 1'b1;
      csr_idx   <= CSR_LINE_COMPARE;
      csr_wdata <= lc;
      @(negedge clock);
      csr_idx   <= CSR_IRQ_ENABLES;
      csr_wdata <= en;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      n_settings++;
   endtask

   initial begin : stimulus
      int         phase;
      int         k;
      logic [7:0] lc_val;
      logic [7:0] en_val;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_idx            = CSR_LINE_COMPARE;
      csr_wdata          = 8'd0;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_TICK;
      req_bus.lcd_enable = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // upper data bits of the enable register must be dropped
      load_settings(8'd0, 8'hF0);
      for (k = 0; k < PLAN_LEN; k++)
         send_word(DIRECTED_PLAN[k].kind, DIRECTED_PLAN[k].enable,
                   DIRECTED_PLAN[k].pinned, DIRECTED_PLAN[k].word);
      req_bus.valid <= 1'b0;
      wait_for_drain();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin lc_val = 8'd0;      en_val = 8'hFF; end
            1: begin lc_val = 8'hFF;     en_val = 8'h00; end
            2: begin lc_val = LAST_LINE; en_val = 8'h04; end
            3: begin
               lc_val = 8'($urandom_range(0, 255));
               en_val = 8'($urandom_range(0, 255));
            end
            4: begin
               lc_val = 8'($urandom_range(0, FIRST_VBLANK_LINE - 1));
               en_val = 8'($urandom_range(0, 255)) | 8'h08;
            end
            default: begin lc_val = FIRST_VBLANK_LINE - 8'd1; en_val = 8'h0F; end
         endcase
         load_settings(lc_val, en_val);
         gaps_on = (phase != 1);
         send_word(REQ_LCDC_WRITE, 1'b1, 1'b0, HELD_OFF);
         for (k = 0; k < PHASE_LEN[phase]; k++) begin
            // stall the response side while requests keep coming
            if (phase == 0 && k == 100) hold_rsp = 1'b1;
            if ($urandom_range(0, 9999) < PHASE_WRITES[phase])
               send_word(REQ_LCDC_WRITE, $urandom_range(0, 3) != 0, 1'b0, HELD_OFF);
            else
               send_word(REQ_TICK, $urandom_range(0, 1) == 1, 1'b0, HELD_OFF);
         end
         req_bus.valid <= 1'b0;
         wait_for_drain();
      end

      $display("Ran %0d request words through %0d register settings, %0d responses checked.",
               n_requests, n_settings, n_results);
      $display("Saw %0d status interrupts, %0d vblank interrupts, %0d rendered lines.",
               n_lcd_irq, n_vblank_irq, n_render);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/lmts_pkg.sv
rtl/lmts_ifs.sv
rtl/lcd_mode_timing_sequencer_core.sv
tb/sv/lcd_mode_timing_sequencer_core_tb.sv
